@@ hw/rtl/tarc_pkg.sv @@
// Shared constants, types and tables of the triplet angle-times-radius check.
`default_nettype none

package tarc_pkg;

    // Defaults of the top-level parameters.
    localparam int COORD_BITS_DEF   = 24;
    localparam int PRODUCT_BITS_DEF = 40;

    // Internal widths. Differences of two coordinates of up to 32 bits fit DIFF_W.
    localparam int DIFF_W     = 34;
    localparam int VW         = 64;   // vectoring datapath
    localparam int MAG_W      = 60;   // vectoring magnitude
    localparam int SH_W       = 6;    // normalizing shift count
    localparam int NORM_STEPS = 6;    // shift by 32, 16, 8, 4, 2, 1
    localparam int NORM_TOP   = 58;   // larger component lands in [2^57, 2^58)
    localparam int STEPS      = 30;   // CORDIC iterations
    localparam int SW         = 34;   // sine datapath
    localparam int DIV_STEPS  = 32;   // quotient bits
    localparam int NUM_W      = 62;   // dividend width
    localparam int G_W        = 60;   // magnitude times gain correction
    localparam int WQ_W       = 52;   // chord length in Q16
    localparam int WQ_HALF    = 26;
    localparam int H_W        = 32;
    localparam int PP_W       = H_W + WQ_HALF;
    localparam int P_W        = 96;
    localparam int PROD_SHIFT = 39;
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 4;

    // Latency of the two units in cycles.
    localparam int VEC_LAT = 1 + NORM_STEPS + 1 + STEPS;
    localparam int H_LAT   = 1 + STEPS + 1 + DIV_STEPS;

    localparam logic [29:0] KINV_Q30 = 30'd652032874;
    localparam logic [31:0] H0_Q24   = 32'd961263669;
    localparam logic [31:0] SMALL_T  = 32'd1048576;

    // Arctangent of 2^-i in turns, 2^32 per turn.
    localparam logic [31:0] TURN_TAB [STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef enum logic [1:0] {
        ST_NORMAL    = 2'd0,
        ST_ZERO_SEG  = 2'd1,
        ST_COLLINEAR = 2'd2
    } status_t;

    // Register index, taken from paddr bit 3.
    localparam logic REG_IDX_MIN = 1'b0;
    localparam logic REG_IDX_MAX = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/tarc_if.sv @@
// Handshake interfaces for the hit triplet items and the result items.
`default_nettype none

interface tarc_hits_if #(
    parameter int COORD_BITS = tarc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] middle_x;
    logic signed [COORD_BITS-1:0] middle_y;
    logic signed [COORD_BITS-1:0] last_x;
    logic signed [COORD_BITS-1:0] last_y;

    modport source (
        output valid, first_x, first_y, middle_x, middle_y, last_x, last_y,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, middle_x, middle_y, last_x, last_y,
        output ready
    );
endinterface

interface tarc_result_if #(
    parameter int PRODUCT_BITS = tarc_pkg::PRODUCT_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    compatible;
    logic [PRODUCT_BITS-1:0] product_value;
    logic [1:0]              status;

    modport source (
        output valid, compatible, product_value, status,
        input  ready
    );
    modport sink (
        input  valid, compatible, product_value, status,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/triplet_angle_times_radius_check_top.sv @@
// Top level of the triplet angle-times-radius check with its register port.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits at the output. It is built of three
// 38-stage CORDIC vectoring units, a sine unit of 30 rotation stages and a
// divider of 32 quotient stages. Reset clears all valid bits and sets the
// window to full range.
`default_nettype none

module triplet_angle_times_radius_check_top #(
    parameter int COORD_BITS   = tarc_pkg::COORD_BITS_DEF,
    parameter int PRODUCT_BITS = tarc_pkg::PRODUCT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tarc_hits_if.sink                     hits,
    tarc_result_if.source                 result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tarc_pkg::APB_AW-1:0]   paddr,
    input  logic [tarc_pkg::APB_DW-1:0]   pwdata,
    output logic [tarc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int DW       = tarc_pkg::DIFF_W;
    localparam int WQ_DLY   = tarc_pkg::H_LAT - 1;
    localparam int STAT_DLY = tarc_pkg::VEC_LAT + tarc_pkg::H_LAT + 2;
    localparam int PTOP     = tarc_pkg::PROD_SHIFT + PRODUCT_BITS;

    function automatic tarc_pkg::diff_t sext(input logic [COORD_BITS-1:0] v);
        return {{(DW - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    logic adv;

    // Window registers.
    logic [PRODUCT_BITS-1:0] pmin_reg;
    logic [PRODUCT_BITS-1:0] pmax_reg;

    // Differences.
    logic            a_valid_reg;
    tarc_pkg::diff_t ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;

    // Degenerate checks.
    logic                  zero_reg;
    logic signed [2*DW-1:0] p1_reg, p2_reg;
    tarc_pkg::status_t     stat_reg;
    tarc_pkg::status_t     stat_dly_reg [STAT_DLY];

    // Vectoring unit outputs.
    logic                            vu_valid, vv_valid, vw_valid;
    logic [31:0]                     ang_u, ang_v, ang_w;
    logic [tarc_pkg::MAG_W-1:0]      mag_u, mag_v, mag_w;
    logic [tarc_pkg::SH_W-1:0]       sh_u, sh_v, sh_w;

    // Angle difference and chord length.
    logic                            tv_reg;
    logic [31:0]                     t_reg, t_next;
    logic [tarc_pkg::G_W-1:0]        g_reg;
    logic [tarc_pkg::SH_W-1:0]       gsh_reg;
    logic [tarc_pkg::WQ_W-1:0]       wq_reg;
    logic [tarc_pkg::WQ_W-1:0]       wq_dly_reg [WQ_DLY];
    logic [31:0]                     d0, d1;

    logic                            h_valid;
    logic [tarc_pkg::H_W-1:0]        h;

    // Product stages.
    logic                            m1v_reg, m2v_reg, m3v_reg;
    logic [tarc_pkg::PP_W-1:0]       plo_reg, phi_reg;
    logic [tarc_pkg::P_W-1:0]        p_reg;
    logic [PRODUCT_BITS-1:0]         val_reg, val_next;

    // Output register.
    logic                            out_valid_reg;
    logic                            out_compat_reg;
    logic [PRODUCT_BITS-1:0]         out_val_reg;
    tarc_pkg::status_t               out_stat_reg;
    logic                            compat_next;
    tarc_pkg::status_t               stat_end;

    assign adv        = !out_valid_reg || result.ready;
    assign hits.ready = adv;

    // Register port: writes land in the access cycle, reads are immediate.
    assign pready = 1'b1;
    assign prdata = (paddr[3] == tarc_pkg::REG_IDX_MAX) ? tarc_pkg::APB_DW'(pmax_reg)
                                                        : tarc_pkg::APB_DW'(pmin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg <= '0;
            pmax_reg <= '1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[3] == tarc_pkg::REG_IDX_MAX)
            begin
                pmax_reg <= pwdata[PRODUCT_BITS-1:0];
            end
            else
            begin
                pmin_reg <= pwdata[PRODUCT_BITS-1:0];
            end
        end
    end

    // Stage 1: segment and chord vectors.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg <= sext(hits.middle_x) - sext(hits.first_x);
            uy_reg <= sext(hits.middle_y) - sext(hits.first_y);
            vx_reg <= sext(hits.last_x) - sext(hits.middle_x);
            vy_reg <= sext(hits.last_y) - sext(hits.middle_y);
            wx_reg <= sext(hits.last_x) - sext(hits.first_x);
            wy_reg <= sext(hits.last_y) - sext(hits.first_y);
        end
    end

    // Stages 2 and 3: zero-length segments and exact cross product test.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg <= ((ux_reg == '0) && (uy_reg == '0)) ||
                        ((vx_reg == '0) && (vy_reg == '0));
            p1_reg   <= ux_reg * vy_reg;
            p2_reg   <= uy_reg * vx_reg;
            if (zero_reg)
            begin
                stat_reg <= tarc_pkg::ST_ZERO_SEG;
            end
            else if (p1_reg == p2_reg)
            begin
                stat_reg <= tarc_pkg::ST_COLLINEAR;
            end
            else
            begin
                stat_reg <= tarc_pkg::ST_NORMAL;
            end
            stat_dly_reg[0] <= stat_reg;
            for (int k = 1; k < STAT_DLY; k++)
            begin
                stat_dly_reg[k] <= stat_dly_reg[k-1];
            end
        end
    end

    tarc_vector u_vec_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_x      (ux_reg),
        .in_y      (uy_reg),
        .out_valid (vu_valid),
        .ang       (ang_u),
        .mag       (mag_u),
        .shift     (sh_u)
    );

    tarc_vector u_vec_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_x      (vx_reg),
        .in_y      (vy_reg),
        .out_valid (vv_valid),
        .ang       (ang_v),
        .mag       (mag_v),
        .shift     (sh_v)
    );

    tarc_vector u_vec_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_x      (wx_reg),
        .in_y      (wy_reg),
        .out_valid (vw_valid),
        .ang       (ang_w),
        .mag       (mag_w),
        .shift     (sh_w)
    );

    // Folded angle between the segments, in [0, a quarter turn].
    always_comb
    begin
        d0     = ang_v - ang_u;
        d1     = (d0 > 32'h8000_0000) ? (32'h0 - d0) : d0;
        t_next = (d1 > 32'h4000_0000) ? (32'h8000_0000 - d1) : d1;
    end

    // Chord magnitude with gain correction, then scaled to Q16.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg   <= t_next;
            g_reg   <= tarc_pkg::G_W'(mag_w[tarc_pkg::MAG_W-1:30]) *
                       tarc_pkg::G_W'(tarc_pkg::KINV_Q30);
            gsh_reg <= sh_w;
            wq_reg  <= tarc_pkg::WQ_W'(g_reg >> (gsh_reg - tarc_pkg::SH_W'(16)));
            wq_dly_reg[0] <= wq_reg;
            for (int k = 1; k < WQ_DLY; k++)
            begin
                wq_dly_reg[k] <= wq_dly_reg[k-1];
            end
        end
    end

    tarc_hcalc u_hcalc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (tv_reg),
        .t         (t_reg),
        .out_valid (h_valid),
        .h         (h)
    );

    // Product H * W over two partial products, then scale and saturate.
    always_comb
    begin
        if (|p_reg[tarc_pkg::P_W-1:PTOP])
        begin
            val_next = '1;
        end
        else
        begin
            val_next = p_reg[PTOP-1:tarc_pkg::PROD_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg <= tarc_pkg::PP_W'(h) *
                       tarc_pkg::PP_W'(wq_dly_reg[WQ_DLY-1][tarc_pkg::WQ_HALF-1:0]);
            phi_reg <= tarc_pkg::PP_W'(h) *
                       tarc_pkg::PP_W'(wq_dly_reg[WQ_DLY-1][tarc_pkg::WQ_W-1:tarc_pkg::WQ_HALF]);
            p_reg   <= tarc_pkg::P_W'(plo_reg) +
                       (tarc_pkg::P_W'(phi_reg) << tarc_pkg::WQ_HALF);
            val_reg <= val_next;
        end
    end

    // Window check; degenerate items pass with a zero product.
    assign stat_end = stat_dly_reg[STAT_DLY-1];

    always_comb
    begin
        if (stat_end != tarc_pkg::ST_NORMAL)
        begin
            compat_next = 1'b1;
        end
        else
        begin
            compat_next = !((val_reg < pmin_reg) || (val_reg > pmax_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_compat_reg <= compat_next;
            out_val_reg    <= (stat_end != tarc_pkg::ST_NORMAL) ? '0 : val_reg;
            out_stat_reg   <= stat_end;
        end
    end

    // Valid bits along the main path.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            tv_reg        <= 1'b0;
            m1v_reg       <= 1'b0;
            m2v_reg       <= 1'b0;
            m3v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= hits.valid;
            tv_reg        <= vu_valid && vv_valid && vw_valid;
            m1v_reg       <= h_valid;
            m2v_reg       <= m1v_reg;
            m3v_reg       <= m2v_reg;
            out_valid_reg <= m3v_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.compatible    = out_compat_reg;
    assign result.product_value = out_val_reg;
    assign result.status        = out_stat_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tarc_vector.sv @@
// Pipelined CORDIC vectoring unit: angle, gain-scaled magnitude and normalizing shift.
`default_nettype none

module tarc_vector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  tarc_pkg::diff_t               in_x,
    input  tarc_pkg::diff_t               in_y,
    output logic                          out_valid,
    output logic [31:0]                   ang,
    output logic [tarc_pkg::MAG_W-1:0]    mag,
    output logic [tarc_pkg::SH_W-1:0]     shift
);

    localparam int NS = tarc_pkg::NORM_STEPS;
    localparam int ST = tarc_pkg::STEPS;
    localparam int VW = tarc_pkg::VW;
    localparam int SHW = tarc_pkg::SH_W;

    // Normalizing stages.
    logic                 nv_reg  [NS+1];
    logic                 nv_next [NS+1];
    logic signed [VW-1:0] nx_reg  [NS+1];
    logic signed [VW-1:0] nx_next [NS+1];
    logic signed [VW-1:0] ny_reg  [NS+1];
    logic signed [VW-1:0] ny_next [NS+1];
    logic [VW-1:0]        nm_reg  [NS+1];
    logic [VW-1:0]        nm_next [NS+1];
    logic [SHW-1:0]       nsh_reg [NS+1];
    logic [SHW-1:0]       nsh_next[NS+1];

    // Rotation stages.
    logic                 cv_reg  [ST+1];
    logic                 cv_next [ST+1];
    logic signed [VW-1:0] cx_reg  [ST+1];
    logic signed [VW-1:0] cx_next [ST+1];
    logic signed [VW-1:0] cy_reg  [ST+1];
    logic signed [VW-1:0] cy_next [ST+1];
    logic [31:0]          cz_reg  [ST+1];
    logic [31:0]          cz_next [ST+1];
    logic [SHW-1:0]       csh_reg [ST+1];
    logic [SHW-1:0]       csh_next[ST+1];

    logic [tarc_pkg::DIFF_W-1:0] abs_x;
    logic [tarc_pkg::DIFF_W-1:0] abs_y;

    // Capture, then shift the vector up until its larger component reaches 2^57.
    always_comb
    begin
        int amt;
        abs_x = in_x[tarc_pkg::DIFF_W-1] ? tarc_pkg::DIFF_W'(-in_x) : in_x;
        abs_y = in_y[tarc_pkg::DIFF_W-1] ? tarc_pkg::DIFF_W'(-in_y) : in_y;
        nv_next[0]  = in_valid;
        nx_next[0]  = VW'(in_x);
        ny_next[0]  = VW'(in_y);
        nm_next[0]  = VW'((abs_x > abs_y) ? abs_x : abs_y);
        nsh_next[0] = '0;
        for (int k = 0; k < NS; k++)
        begin
            amt = 1 << (NS - 1 - k);
            nv_next[k+1] = nv_reg[k];
            if (nm_reg[k] < (VW'(1) << (tarc_pkg::NORM_TOP - amt)))
            begin
                nx_next[k+1]  = nx_reg[k] <<< amt;
                ny_next[k+1]  = ny_reg[k] <<< amt;
                nm_next[k+1]  = nm_reg[k] << amt;
                nsh_next[k+1] = nsh_reg[k] + SHW'(amt);
            end
            else
            begin
                nx_next[k+1]  = nx_reg[k];
                ny_next[k+1]  = ny_reg[k];
                nm_next[k+1]  = nm_reg[k];
                nsh_next[k+1] = nsh_reg[k];
            end
        end
    end

    // Half-turn into the right half plane, then the vectoring iterations.
    always_comb
    begin
        cv_next[0]  = nv_reg[NS];
        csh_next[0] = nsh_reg[NS];
        if (nx_reg[NS] < 0)
        begin
            cx_next[0] = -nx_reg[NS];
            cy_next[0] = -ny_reg[NS];
            cz_next[0] = 32'h8000_0000;
        end
        else
        begin
            cx_next[0] = nx_reg[NS];
            cy_next[0] = ny_reg[NS];
            cz_next[0] = '0;
        end
        for (int i = 0; i < ST; i++)
        begin
            cv_next[i+1]  = cv_reg[i];
            csh_next[i+1] = csh_reg[i];
            if (cy_reg[i] > 0)
            begin
                cx_next[i+1] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] + tarc_pkg::TURN_TAB[i];
            end
            else
            begin
                cx_next[i+1] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] - tarc_pkg::TURN_TAB[i];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= '{default: 1'b0};
            cv_reg <= '{default: 1'b0};
        end
        else if (en)
        begin
            nv_reg <= nv_next;
            cv_reg <= cv_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            nm_reg  <= nm_next;
            nsh_reg <= nsh_next;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            cz_reg  <= cz_next;
            csh_reg <= csh_next;
        end
    end

    assign out_valid = cv_reg[ST];
    assign ang       = cz_reg[ST];
    assign mag       = (cx_reg[ST] > 0) ? cx_reg[ST][tarc_pkg::MAG_W-1:0] : '0;
    assign shift     = csh_reg[ST];

endmodule

`default_nettype wire

@@ hw/rtl/tarc_hcalc.sv @@
// Pipelined sine and divider: angle over sine of the angle, degrees in Q24.
`default_nettype none

module tarc_hcalc (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [31:0]               t,
    output logic                      out_valid,
    output logic [tarc_pkg::H_W-1:0]  h
);

    localparam int ST = tarc_pkg::STEPS;
    localparam int DS = tarc_pkg::DIV_STEPS;
    localparam int SW = tarc_pkg::SW;
    localparam int NW = tarc_pkg::NUM_W;

    // Sine rotation stages.
    logic                 sv_reg  [ST+1];
    logic                 sv_next [ST+1];
    logic signed [SW-1:0] sx_reg  [ST+1];
    logic signed [SW-1:0] sx_next [ST+1];
    logic signed [SW-1:0] sy_reg  [ST+1];
    logic signed [SW-1:0] sy_next [ST+1];
    logic signed [SW-1:0] sz_reg  [ST+1];
    logic signed [SW-1:0] sz_next [ST+1];
    logic [31:0]          st_reg  [ST+1];
    logic [31:0]          st_next [ST+1];
    logic                 ssm_reg [ST+1];
    logic                 ssm_next[ST+1];

    // Restoring divider stages.
    logic        dv_reg  [DS+1];
    logic        dv_next [DS+1];
    logic [31:0] dr_reg  [DS+1];
    logic [31:0] dr_next [DS+1];
    logic [31:0] dn_reg  [DS+1];
    logic [31:0] dn_next [DS+1];
    logic [31:0] dq_reg  [DS+1];
    logic [31:0] dq_next [DS+1];
    logic [31:0] ds_reg  [DS+1];
    logic [31:0] ds_next [DS+1];
    logic        dsm_reg [DS+1];
    logic        dsm_next[DS+1];

    logic [NW-1:0] num;
    logic [32:0]   trial [DS];

    // Sine of t by rotation from (1/K, 0).
    always_comb
    begin
        sv_next[0]  = in_valid;
        sx_next[0]  = SW'(tarc_pkg::KINV_Q30);
        sy_next[0]  = '0;
        sz_next[0]  = SW'(t);
        st_next[0]  = t;
        ssm_next[0] = (t < tarc_pkg::SMALL_T);
        for (int i = 0; i < ST; i++)
        begin
            sv_next[i+1]  = sv_reg[i];
            st_next[i+1]  = st_reg[i];
            ssm_next[i+1] = ssm_reg[i];
            if (sz_reg[i] >= 0)
            begin
                sx_next[i+1] = sx_reg[i] - (sy_reg[i] >>> i);
                sy_next[i+1] = sy_reg[i] + (sx_reg[i] >>> i);
                sz_next[i+1] = sz_reg[i] - SW'(tarc_pkg::TURN_TAB[i]);
            end
            else
            begin
                sx_next[i+1] = sx_reg[i] + (sy_reg[i] >>> i);
                sy_next[i+1] = sy_reg[i] - (sx_reg[i] >>> i);
                sz_next[i+1] = sz_reg[i] + SW'(tarc_pkg::TURN_TAB[i]);
            end
        end
    end

    // Dividend t*360*2^22 over the sine, one quotient bit per stage.
    always_comb
    begin
        num = (NW'(st_reg[ST]) * NW'(360)) << 22;
        dv_next[0]  = sv_reg[ST];
        dr_next[0]  = 32'(num[NW-1:32]);
        dn_next[0]  = num[31:0];
        dq_next[0]  = '0;
        ds_next[0]  = (sy_reg[ST] <= 0) ? 32'd1 : sy_reg[ST][31:0];
        dsm_next[0] = ssm_reg[ST];
        for (int j = 0; j < DS; j++)
        begin
            trial[j]      = {dr_reg[j], dn_reg[j][31]};
            dv_next[j+1]  = dv_reg[j];
            dn_next[j+1]  = dn_reg[j] << 1;
            ds_next[j+1]  = ds_reg[j];
            dsm_next[j+1] = dsm_reg[j];
            if (trial[j] >= {1'b0, ds_reg[j]})
            begin
                dr_next[j+1] = 32'(trial[j] - {1'b0, ds_reg[j]});
                dq_next[j+1] = {dq_reg[j][30:0], 1'b1};
            end
            else
            begin
                dr_next[j+1] = trial[j][31:0];
                dq_next[j+1] = {dq_reg[j][30:0], 1'b0};
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '{default: 1'b0};
            dv_reg <= '{default: 1'b0};
        end
        else if (en)
        begin
            sv_reg <= sv_next;
            dv_reg <= dv_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sz_reg  <= sz_next;
            st_reg  <= st_next;
            ssm_reg <= ssm_next;
            dr_reg  <= dr_next;
            dn_reg  <= dn_next;
            dq_reg  <= dq_next;
            ds_reg  <= ds_next;
            dsm_reg <= dsm_next;
        end
    end

    // Very small angles use the limit value 180/pi.
    assign out_valid = dv_reg[DS];
    assign h         = dsm_reg[DS] ? tarc_pkg::H0_Q24 : dq_reg[DS];

endmodule

`default_nettype wire
